[src/sequence_window_buffer_unit_defines.svh]
// assertion macros used by the window buffer rtl
// no dependencies; included by the files that carry assertions
`ifndef SEQUENCE_WINDOW_BUFFER_UNIT_DEFINES_SVH
`define SEQUENCE_WINDOW_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window buffer check failed");

// next-cycle implication, checked outside reset
`define SWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window buffer check failed");

`endif

[src/swb_pkg.sv]
// types, codes and constants of the sequence window buffer
// no dependencies
package swb_pkg;

  localparam int SEQ_W     = 31;
  localparam int LEN_W     = 11;
  localparam int HANDLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_OUT_W = 5;

  // largest payload length that is stored or added to the next sequence
  localparam logic [LEN_W-1:0] LEN_MAX = 11'd1024;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SEQ_W-1:0]    seq_number;
    logic [LEN_W-1:0]    payload_length;
    logic [HANDLE_W-1:0] payload_handle;
    logic [TIME_W-1:0]   time_now;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [SEQ_W-1:0]     assigned_seq;
    logic [CNT_OUT_W-1:0] removed_count;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [LEN_W-1:0]    length;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   send_time;
  } entry_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } ctrl_res_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    clamp_len = (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

endpackage

[src/swb_mem.sv]
// entry storage of the window buffer: one write port, one registered read port
// depends on swb_pkg
module swb_mem import swb_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/swb_ctrl.sv]
// sequencer of the window buffer: ring pointers, shared sequence compare, entry moves
// depends on swb_pkg, swb_mem port timing and the assertion macro header
`include "sequence_window_buffer_unit_defines.svh"

module swb_ctrl import swb_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  in_item_t      item,
  output logic          idle,
  input  logic          res_ready,
  output ctrl_res_t     res,
  output logic          mem_wr_en,
  output logic [IW-1:0] mem_wr_addr,
  output entry_t        mem_wr_data,
  output logic [IW-1:0] mem_rd_addr,
  input  entry_t        mem_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_FINISH
  } state_t;

  state_t               state_r;
  in_item_t             item_r;
  logic [IW-1:0]        head_r;
  logic [IW-1:0]        tail_r;
  logic [IW-1:0]        ptr_r;
  logic [IW-1:0]        sp_r;
  logic [IW-1:0]        wr_addr_r;
  logic                 wr_pend_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        pos_r;
  logic [SEQ_W-1:0]     next_seq_r;
  status_e              status_r;
  logic [SEQ_W-1:0]     assigned_r;
  logic [CNT_OUT_W-1:0] removed_r;

  logic     seq_lt;
  logic     seq_eq;
  logic     full;
  logic     at_end;
  entry_t   new_entry;
  in_item_t item_in;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
    ptr_dec = (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // shared compare against the entry read in the previous cycle
  assign seq_lt = mem_rd_data.seq < item_r.seq_number;
  assign seq_eq = mem_rd_data.seq == item_r.seq_number;
  assign full   = cnt_r == CW'(DEPTH);
  assign at_end = pos_r == cnt_r;

  // incoming request with its length saturated
  always_comb begin
    item_in                = item;
    item_in.payload_length = clamp_len(item.payload_length);
  end

  always_comb begin
    new_entry.seq       = (item_r.cmd == CMD_APPEND) ? next_seq_r : item_r.seq_number;
    new_entry.length    = item_r.payload_length;
    new_entry.handle    = item_r.payload_handle;
    new_entry.send_time = item_r.time_now;
  end

  always_comb begin
    unique case (state_r)
      S_SCAN:  mem_rd_addr = ptr_inc(ptr_r);
      S_SHIFT: mem_rd_addr = ptr_dec(sp_r);
      default: mem_rd_addr = head_r;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_SHIFT: begin
        mem_wr_en   = wr_pend_r;
        mem_wr_addr = wr_addr_r;
        mem_wr_data = mem_rd_data;
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r;
        mem_wr_data = new_entry;
      end
      default: begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_r;
        mem_wr_data = new_entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
      pos_r      <= '0;
      wr_pend_r  <= 1'b0;
      next_seq_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r     <= item_in;
            status_r   <= ST_DONE;
            assigned_r <= '0;
            removed_r  <= '0;
            pos_r      <= '0;
            unique case (item.cmd)
              CMD_INSERT, CMD_ACK: begin
                ptr_r   <= head_r;
                state_r <= S_SCAN;
              end
              CMD_APPEND: begin
                ptr_r <= tail_r;
                if (full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_FINISH;
                end else begin
                  state_r <= S_PUT;
                end
              end
              CMD_NOP: state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          priority if (!at_end && seq_lt) begin
            pos_r <= pos_r + 1'b1;
            ptr_r <= ptr_inc(ptr_r);
          end else if (item_r.cmd == CMD_ACK) begin
            // drop everything ahead of the stop point by moving the head
            removed_r <= CNT_OUT_W'(pos_r);
            head_r    <= ptr_r;
            cnt_r     <= cnt_r - pos_r;
            state_r   <= S_FINISH;
          end else if (!at_end && seq_eq) begin
            status_r <= ST_DUP;
            state_r  <= S_FINISH;
          end else if (full) begin
            status_r <= ST_FULL;
            state_r  <= S_FINISH;
          end else begin
            sp_r      <= tail_r;
            wr_pend_r <= 1'b0;
            state_r   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // read one slot below the destination, write it in the next cycle
          if (sp_r != ptr_r) begin
            wr_addr_r <= sp_r;
            wr_pend_r <= 1'b1;
            sp_r      <= ptr_dec(sp_r);
          end else begin
            wr_pend_r <= 1'b0;
            if (!wr_pend_r) begin
              state_r <= S_PUT;
            end
          end
        end
        S_PUT: begin
          cnt_r  <= cnt_r + 1'b1;
          tail_r <= ptr_inc(tail_r);
          if (item_r.cmd == CMD_APPEND) begin
            assigned_r <= next_seq_r;
            next_seq_r <= next_seq_r + SEQ_W'(item_r.payload_length);
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle                   = state_r == S_IDLE;
  assign res.valid              = state_r == S_FINISH;
  assign res.item.status        = status_r;
  assign res.item.assigned_seq  = assigned_r;
  assign res.item.removed_count = removed_r;
  assign res.item.entry_count   = CNT_OUT_W'(cnt_r);

  `SWB_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `SWB_ASSERT_NOW(a_empty_ring, clk, rst_n, cnt_r == '0, head_r == tail_r)
  `SWB_ASSERT_NOW(a_put_not_full, clk, rst_n, state_r == S_PUT, !full)
  `SWB_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == S_SCAN, pos_r <= cnt_r)
  `SWB_ASSERT_NEXT(a_shift_to_put, clk, rst_n,
                   state_r == S_SHIFT && sp_r == ptr_r && !wr_pend_r, state_r == S_PUT)

endmodule

[src/sequence_window_buffer_unit.sv]
// Sequence window buffer top level.
// Channels: in_valid/in_stall/in_data carries one request (cmd, seq_number,
// payload_length, payload_handle, time_now); out_valid/out_stall/out_data
// carries one result per request (status, assigned_seq, removed_count,
// entry_count). A transfer happens on a clock edge with valid high and stall low.
// Requests are handled one at a time; in_stall stays high from acceptance until
// the result has moved into the output register.
// Insert scans the entries in order up to the sorted position, then moves the
// entries from that position on up by one slot and writes the new entry; a
// duplicate or a full window ends the request at the stop point of the scan.
// Acknowledge scans the entries it removes; append writes at the tail directly;
// a full append and an unused command go straight to the result.
// The ring memory gives one entry per cycle to the
// shared sequence compare during the scan and to the entry move loop.
// Acknowledge only moves the ring head, so it costs no entry moves.
// The output register lets a new request be taken while the last result waits.
// A stalled result holds; a request finishing meanwhile waits in its last state.
// Reset (rst_n low, synchronous) empties the window and zeroes the next sequence.
// depends on swb_pkg, swb_ctrl and swb_mem
module sequence_window_buffer_unit import swb_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(DEPTH);

  logic          ctrl_idle;
  logic          res_ready;
  ctrl_res_t     res;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic [IW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_stall  = !ctrl_idle;
  // result can move in when the output register is empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  swb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && ctrl_idle),
    .item        (in_data),
    .idle        (ctrl_idle),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  swb_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res.item;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
